// ===== hw/rtl/iee_pkg.sv =====
`default_nettype none
package iee_pkg;
  localparam int unsigned VAL_W = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;

  typedef struct packed {
    logic op_push;
    logic op_pop;
    logic val_push;
    logic load_ops;
    logic alu_start;
    logic alu_write;
    logic read_top;
    logic clear;
    logic flag_en;
    status_t flag_code;
  } iee_cmd_t;

  typedef struct packed {
    logic op_empty;
    logic op_full;
    logic val_empty;
    logic val_full;
    logic val_lt2;
    logic top_high;
    logic alu_done;
    logic divzero;
    logic rd_ready;
  } iee_sts_t;

  function automatic logic prec_high(input op_t op);
    return (op == OP_MUL) || (op == OP_DIV);
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/iee_if.sv =====
`default_nettype none
interface iee_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] token;
  logic       last;
  modport source (output valid, token, last, input ready);
  modport sink   (input valid, token, last, output ready);
endinterface

interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/infix_expression_evaluator.sv =====
// Infix expression evaluator: takes one ASCII token per transaction (digits
// 0-9 as operands, + - * / as operators, anything else ends the expression,
// as does a token with last set) and returns one signed 32-bit value with a
// 2-bit status per expression (0 ok, 1 operand missing, 2 divide by zero,
// 3 stack overflow; the first error is kept). An operator first pops and
// applies each stacked operator of equal or higher precedence; a popped
// divide with a nonzero divisor runs a radix-2 divider. Ending an
// expression applies all stacked operators the same way and then reads the
// top value into a register to present it; input stays stalled until the
// result transaction completes. Operator and value stacks are
// memories in the datapath with registered reads.
`default_nettype none
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int unsigned OPERATOR_DEPTH = 64,
  parameter int unsigned VALUE_DEPTH    = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  iee_in_if.sink    in_ch,
  iee_out_if.source out_ch
);
  iee_cmd_t    cmd;
  iee_sts_t    sts;
  op_t         new_op;
  logic [3:0]  digit;
  logic [31:0] top_value;

  iee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .sts       (sts),
    .top_value (top_value),
    .cmd       (cmd),
    .new_op    (new_op),
    .digit     (digit)
  );

  iee_datapath #(
    .OPERATOR_DEPTH (OPERATOR_DEPTH),
    .VALUE_DEPTH    (VALUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .new_op    (new_op),
    .digit     (digit),
    .sts       (sts),
    .top_value (top_value)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/iee_alu.sv =====
`default_nettype none
module iee_alu
  import iee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire op_t         op,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic             divzero,
  output logic [31:0]      result
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [31:0] res_r, res_nxt;
  logic        dz_r, dz_nxt;
  logic [32:0] trial;
  logic [31:0] ua, ub;

  assign ua = a[31] ? (32'd0 - a) : a;
  assign ub = b[31] ? (32'd0 - b) : b;
  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    res_nxt  = res_r;
    dz_nxt   = dz_r;
    if (start) begin
      dz_nxt = 1'b0;
      unique case (op)
        OP_ADD: begin res_nxt = a + b; done_nxt = 1'b1; end
        OP_SUB: begin res_nxt = a - b; done_nxt = 1'b1; end
        OP_MUL: begin res_nxt = a * b; done_nxt = 1'b1; end
        OP_DIV: begin
          if (b == 32'd0) begin
            res_nxt  = 32'd0;
            dz_nxt   = 1'b1;
            done_nxt = 1'b1;
          end else begin
            busy_nxt = 1'b1;
            neg_nxt  = a[31] ^ b[31];
            rem_nxt  = 32'd0;
            quo_nxt  = ua;
            dvs_nxt  = ub;
            cnt_nxt  = 6'd32;
          end
        end
        default: ;
      endcase
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (32'd0 - quo_nxt) : quo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    res_r <= res_nxt;
    dz_r  <= dz_nxt;
  end

  assign done    = done_r;
  assign divzero = dz_r;
  assign result  = res_r;
endmodule
`default_nettype wire

// ===== hw/rtl/iee_datapath.sv =====
`default_nettype none
module iee_datapath
  import iee_pkg::*;
#(
  parameter int unsigned OPERATOR_DEPTH = 64,
  parameter int unsigned VALUE_DEPTH    = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire iee_cmd_t    cmd,
  input  wire op_t         new_op,
  input  wire logic [3:0]  digit,
  output iee_sts_t         sts,
  output logic [31:0]      top_value
);
  localparam int unsigned OA = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
  localparam int unsigned VA = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

  op_t         op_mem [OPERATOR_DEPTH];
  logic [31:0] val_mem [VALUE_DEPTH];

  logic [OA:0] ocnt_r, ocnt_nxt;
  logic [VA:0] vcnt_r, vcnt_nxt;
  op_t         otop_r;
  op_t         peek_r;
  logic [31:0] ra_r, rb_r;
  logic        rd_r;
  logic [VA:0] rd_ptr;
  logic [OA:0] peek_ptr;
  logic        alu_done, alu_dz;
  logic [31:0] alu_res;
  logic        loaded_r;

  assign peek_ptr = ocnt_nxt - (OA+1)'(1);
  assign rd_ptr   = vcnt_r - (VA+1)'(1);

  always_ff @(posedge clk) begin
    if (cmd.op_push) op_mem[ocnt_r[OA-1:0]] <= new_op;
    if (cmd.op_push) peek_r <= new_op;
    else             peek_r <= op_mem[peek_ptr[OA-1:0]];
    if (cmd.op_pop)  otop_r <= peek_r;
    if (cmd.val_push) val_mem[vcnt_r[VA-1:0]] <= {28'd0, digit};
    if (cmd.alu_write) val_mem[rd_ptr[VA-1:0] - VA'(1)] <= alu_res;
    if (cmd.load_ops) begin
      rb_r <= val_mem[rd_ptr[VA-1:0]];
      ra_r <= val_mem[rd_ptr[VA-1:0] - VA'(1)];
    end
    if (cmd.read_top) rb_r <= val_mem[rd_ptr[VA-1:0]];
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    vcnt_nxt = vcnt_r;
    if (cmd.op_push) ocnt_nxt = ocnt_r + (OA+1)'(1);
    if (cmd.op_pop)  ocnt_nxt = ocnt_r - (OA+1)'(1);
    if (cmd.val_push) vcnt_nxt = vcnt_r + (VA+1)'(1);
    if (cmd.alu_write) vcnt_nxt = vcnt_r - (VA+1)'(1);
    if (cmd.clear) begin
      ocnt_nxt = '0;
      vcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r   <= '0;
      vcnt_r   <= '0;
      rd_r     <= 1'b0;
      loaded_r <= 1'b0;
    end else begin
      ocnt_r   <= ocnt_nxt;
      vcnt_r   <= vcnt_nxt;
      rd_r     <= cmd.read_top | cmd.load_ops | cmd.op_pop;
      loaded_r <= cmd.load_ops;
    end
  end

  iee_alu u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.alu_start),
    .op      (otop_r),
    .a       (ra_r),
    .b       (rb_r),
    .done    (alu_done),
    .divzero (alu_dz),
    .result  (alu_res)
  );

  assign sts.op_empty  = (ocnt_r == '0);
  assign sts.op_full   = (ocnt_r >= (OA+1)'(OPERATOR_DEPTH));
  assign sts.val_empty = (vcnt_r == '0);
  assign sts.val_full  = (vcnt_r >= (VA+1)'(VALUE_DEPTH));
  assign sts.val_lt2   = (vcnt_r < (VA+1)'(2));
  assign sts.top_high  = prec_high(peek_r);
  assign sts.alu_done  = alu_done;
  assign sts.divzero   = alu_dz;
  assign sts.rd_ready  = rd_r & ~loaded_r;
  assign top_value     = rb_r;
endmodule
`default_nettype wire

// ===== hw/rtl/iee_ctrl.sv =====
`default_nettype none
module iee_ctrl
  import iee_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  iee_in_if.sink           in_ch,
  iee_out_if.source        out_ch,
  input  wire iee_sts_t    sts,
  input  wire logic [31:0] top_value,
  output iee_cmd_t         cmd,
  output op_t              new_op,
  output logic [3:0]       digit
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_POP   = 9'b000000100,
    S_LOAD  = 9'b000001000,
    S_WAIT  = 9'b000010000,
    S_ALU   = 9'b000100000,
    S_FIN   = 9'b001000000,
    S_READ  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t      state_r, state_nxt;
  logic        ending_r, ending_nxt;
  logic        hasop_r, hasop_nxt;
  op_t         op_r, op_nxt;
  status_t     err_r, err_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic        is_digit, is_op;
  op_t         tok_op;
  logic        flag_en;
  status_t     flag_code;

  always_comb begin
    is_op  = 1'b1;
    tok_op = OP_ADD;
    priority if (in_ch.token == CH_ADD) tok_op = OP_ADD;
    else if (in_ch.token == CH_SUB) tok_op = OP_SUB;
    else if (in_ch.token == CH_MUL) tok_op = OP_MUL;
    else if (in_ch.token == CH_DIV) tok_op = OP_DIV;
    else is_op = 1'b0;
  end
  assign is_digit = (in_ch.token >= CH_ZERO) && (in_ch.token <= CH_NINE);
  assign digit    = 4'(in_ch.token - CH_ZERO);
  assign new_op   = op_r;

  always_comb begin
    state_nxt  = state_r;
    ending_nxt = ending_r;
    hasop_nxt  = hasop_r;
    op_nxt     = op_r;
    err_nxt    = err_r;
    oval_nxt   = oval_r;
    ost_nxt    = ost_r;
    cmd        = '0;
    flag_en    = 1'b0;
    flag_code  = ST_OK;
    in_ch.ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          ending_nxt = in_ch.last | ~(is_digit | is_op);
          hasop_nxt  = is_op;
          op_nxt     = tok_op;
          if (is_digit) begin
            if (sts.val_full) begin
              flag_en = 1'b1; flag_code = ST_OVERFLOW;
            end else begin
              cmd.val_push = 1'b1;
            end
            state_nxt = in_ch.last ? S_FIN : S_IDLE;
          end else if (is_op) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CHECK: begin
        if (hasop_r) begin
          if (!sts.op_empty && (sts.top_high || !prec_high(op_r))) begin
            cmd.op_pop = 1'b1;
            state_nxt  = S_POP;
          end else begin
            if (sts.op_full) begin
              flag_en = 1'b1; flag_code = ST_OVERFLOW;
            end else begin
              cmd.op_push = 1'b1;
            end
            hasop_nxt = 1'b0;
            state_nxt = ending_r ? S_FIN : S_IDLE;
          end
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_POP: begin
        if (sts.val_lt2) begin
          flag_en = 1'b1; flag_code = ST_MISSING;
          state_nxt = hasop_r ? S_CHECK : S_FIN;
        end else begin
          cmd.load_ops = 1'b1;
          state_nxt    = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.alu_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (sts.alu_done) begin
          cmd.alu_write = 1'b1;
          if (sts.divzero) begin
            flag_en = 1'b1; flag_code = ST_DIVZERO;
          end
          state_nxt = S_ALU;
        end
      end
      S_ALU: begin
        state_nxt = hasop_r ? S_CHECK : S_FIN;
      end
      S_FIN: begin
        if (!sts.op_empty) begin
          cmd.op_pop = 1'b1;
          state_nxt  = S_POP;
        end else begin
          cmd.read_top = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        if (sts.val_empty) begin
          oval_nxt = 32'd0;
          ost_nxt  = (err_r == ST_OK) ? ST_MISSING : err_r;
        end else begin
          oval_nxt = top_value;
          ost_nxt  = err_r;
        end
        cmd.clear = 1'b1;
        err_nxt   = ST_OK;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (flag_en && err_r == ST_OK) err_nxt = flag_code;
    cmd.flag_en   = flag_en;
    cmd.flag_code = flag_code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      err_r    <= ST_OK;
      ending_r <= 1'b0;
      hasop_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      err_r    <= err_nxt;
      ending_r <= ending_nxt;
      hasop_r  <= hasop_nxt;
    end
    op_r   <= op_nxt;
    oval_r <= oval_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_ch.valid  = (state_r == S_OUT);
  assign out_ch.value  = oval_r;
  assign out_ch.status = ost_r;
endmodule
`default_nettype wire

// ===== hw/rtl/iee_checker.sv =====
`default_nettype none
module iee_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value,
  input wire logic [1:0]  out_status
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_value, out_status}))
    else $error("unknown bits on result");
  a_no_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result presented right after input transaction");
  a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("block not idle after result transaction");
endmodule

bind infix_expression_evaluator iee_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value),
  .out_status (out_ch.status)
);
`default_nettype wire
